FILE: rtl/msd_pkg.sv
// Shared types and constants for the mean square displacement block.
// No dependencies; compiled first.
package msd_pkg;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ATOM_COUNT  = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_TYPE = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 8'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_RANGE  = 8'd4;

	localparam int FC_W      = 11;
	localparam int AC_W      = 7;
	localparam int TYPE_W    = 7;
	localparam int PC_W      = 6;
	localparam int TR_W      = 17;
	localparam int LAG_OUT_W = 11;
	localparam int MSD_W     = 36;

	localparam int ACC_W = 64;
	localparam int DIV_N = 64;
	localparam int DIV_D = 32;
	localparam int NUM_W = 48;
	localparam int P1_W  = PC_W + TR_W;

	localparam logic [TR_W-1:0] TR_ONE = 17'd65536;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

FILE: rtl/msd_if.sv
// Handshake channels of the mean square displacement block.
// Depends on msd_pkg.
interface msd_in_if #(parameter int COORD_BITS = 16);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_BITS-1:0]  pos_x;
	logic signed [COORD_BITS-1:0]  pos_y;
	logic signed [COORD_BITS-1:0]  pos_z;
	logic [msd_pkg::TYPE_W-1:0]    atom_type;
	logic                          last_record;
	modport source(output valid, pos_x, pos_y, pos_z, atom_type, last_record, input ready);
	modport sink(input valid, pos_x, pos_y, pos_z, atom_type, last_record, output ready);
endinterface

interface msd_out_if;
	logic                          valid;
	logic                          ready;
	logic [msd_pkg::LAG_OUT_W-1:0] lag_frames;
	logic [msd_pkg::MSD_W-1:0]     msd_value;
	logic                          last_point;
	modport source(output valid, lag_frames, msd_value, last_point, input ready);
	modport sink(input valid, lag_frames, msd_value, last_point, output ready);
endinterface

interface msd_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [msd_pkg::CFG_IDX_W-1:0]  index;
	logic [msd_pkg::CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: rtl/msd_ram.sv
// Generic RAM: one write port, two registered read ports.
// No dependencies.
module msd_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
	input  logic [W-1:0]                         wdata,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr0,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr1,
	output logic [W-1:0]                         rdata0,
	output logic [W-1:0]                         rdata1
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end
endmodule

FILE: rtl/msd_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on msd_pkg (status struct, widths).
module msd_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [msd_pkg::DIV_N-1:0] dividend,
	input  logic [msd_pkg::DIV_D-1:0] divisor,
	output logic [msd_pkg::DIV_N-1:0] quotient,
	output msd_pkg::div_stat_t        stat
);
	import msd_pkg::*;

	localparam int CW = $clog2(DIV_N + 1);

	logic [DIV_D-1:0] rem_q;
	logic [DIV_D-1:0] dvs_q;
	logic [DIV_N-1:0] quo_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DIV_D:0]   rem_sh;
	logic [DIV_D:0]   rem_sub;
	logic             fits;

	always_comb begin
		rem_sh  = {rem_q, quo_q[DIV_N-1]};
		fits    = rem_sh >= {1'b0, dvs_q};
		rem_sub = rem_sh - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIV_N);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub[DIV_D-1:0] : rem_sh[DIV_D-1:0];
			quo_q <= {quo_q[DIV_N-2:0], fits};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;
endmodule

FILE: rtl/mean_square_displacement_core.sv
// Mean square displacement, direct time average over a stored trajectory.
// Depends on msd_pkg, msd_if, msd_ram, msd_div.
//
//   channel  dir  contents
//   traj     in   pos_x, pos_y, pos_z, atom_type, last_record
//   result   out  lag_frames, msd_value, last_point
//   cfg      in   index, data (register write)
//
// traj is ready throughout loading. After last_record a type sweep counts the
// target atoms. Each lag point then runs the lag divide; a point with windows
// and target atoms also runs the final divide and a pass over the frame pairs
// of each target atom, since the position RAM delivers one displacement pair
// per cycle. traj is held off for the whole compute phase; a stalled result
// holds the next point back.
// Reset clears control only; the RAMs hold garbage until loaded.
module mean_square_displacement_core #(
	parameter int MAX_FRAMES = 1024,
	parameter int MAX_ATOMS  = 64,
	parameter int COORD_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	msd_in_if.sink     traj,
	msd_out_if.source  result,
	msd_cfg_if.sink    cfg
);
	import msd_pkg::*;

	localparam int FW    = $clog2(MAX_FRAMES + 1);
	localparam int AW    = $clog2(MAX_ATOMS + 1);
	localparam int AIW   = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
	localparam int DEPTH = MAX_FRAMES * MAX_ATOMS;
	localparam int ADW   = $clog2(DEPTH);
	localparam int PW    = 3 * COORD_BITS;
	localparam int DW    = COORD_BITS + 1;
	localparam int SQW   = 2 * DW;

	localparam logic [3:0] ST_LOAD     = 4'd0;
	localparam logic [3:0] ST_CNT_RD   = 4'd1;
	localparam logic [3:0] ST_CNT_CHK  = 4'd2;
	localparam logic [3:0] ST_LAG_M1   = 4'd3;
	localparam logic [3:0] ST_LAG_M2   = 4'd4;
	localparam logic [3:0] ST_LAG_DIV  = 4'd5;
	localparam logic [3:0] ST_LAG_CHK  = 4'd6;
	localparam logic [3:0] ST_ATOM_RD  = 4'd7;
	localparam logic [3:0] ST_ATOM_CHK = 4'd8;
	localparam logic [3:0] ST_PAIR     = 4'd9;
	localparam logic [3:0] ST_DRAIN    = 4'd10;
	localparam logic [3:0] ST_SUM_M    = 4'd11;
	localparam logic [3:0] ST_SUM_DIV  = 4'd12;
	localparam logic [3:0] ST_EMIT     = 4'd13;

	// configuration
	logic [FC_W-1:0]   fc_q;
	logic [AC_W-1:0]   ac_q;
	logic [TYPE_W-1:0] tt_q;
	logic [PC_W-1:0]   pc_q;
	logic [TR_W-1:0]   tr_q;

	logic [FW-1:0]   nf;
	logic [AW-1:0]   na;
	logic [PC_W-1:0] res;
	logic [TR_W-1:0] tr;

	logic [3:0]       state_q;
	logic [FW-1:0]    fr_q;
	logic [AIW-1:0]   at_q;
	logic [ADW-1:0]   base_q;
	logic [AIW-1:0]   j_q;
	logic [AW-1:0]    tcnt_q;
	logic [PC_W-1:0]  i_q;
	logic [P1_W-1:0]  p1_q;
	logic [NUM_W-1:0] num_q;
	logic [FW-1:0]    lag_q;
	logic [FW-1:0]    win_q;
	logic [FW-1:0]    k_q;
	logic [ADW-1:0]   a0_q;
	logic [ADW-1:0]   a1_q;
	logic [ACC_W-1:0] acc_q;
	logic [DIV_D-1:0] dvs_q;
	logic [MSD_W-1:0] val_q;
	logic             go_q;

	logic             ov_q;
	logic [FW-1:0]    olag_q;
	logic [MSD_W-1:0] oval_q;
	logic             olast_q;

	logic             acc_in;
	logic             pos_we;
	logic             typ_we;
	logic [ADW-1:0]   ld_addr;
	logic             atom_last;
	logic             load_last;
	logic             emit_ok;
	logic [PW-1:0]    rd0;
	logic [PW-1:0]    rd1;
	logic [TYPE_W-1:0] typ_rd;
	logic             type_hit;

	logic [DIV_N-1:0] div_num;
	logic [DIV_D-1:0] div_dvs;
	logic [DIV_N-1:0] div_quo;
	div_stat_t        div_stat;

	logic                   v_s1;
	logic                   v_s2;
	logic                   v_s3;
	logic signed [DW-1:0]   dx_s2;
	logic signed [DW-1:0]   dy_s2;
	logic signed [DW-1:0]   dz_s2;
	logic signed [SQW-1:0]  sx_s3;
	logic signed [SQW-1:0]  sy_s3;
	logic signed [SQW-1:0]  sz_s3;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q <= 11'd1024;
			ac_q <= 7'd64;
			tt_q <= '0;
			pc_q <= 6'd63;
			tr_q <= 17'd32768;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_FRAME_COUNT: fc_q <= cfg.data[FC_W-1:0];
				REG_ATOM_COUNT:  ac_q <= cfg.data[AC_W-1:0];
				REG_TARGET_TYPE: tt_q <= cfg.data[TYPE_W-1:0];
				REG_POINT_COUNT: pc_q <= cfg.data[PC_W-1:0];
				REG_TIME_RANGE:  tr_q <= cfg.data[TR_W-1:0];
				default: ;
			endcase
		end
	end

	// clamped register values
	always_comb begin
		if (fc_q == '0) begin
			nf = FW'(1);
		end else if (32'(fc_q) > MAX_FRAMES) begin
			nf = FW'(MAX_FRAMES);
		end else begin
			nf = FW'(fc_q);
		end
		if (ac_q == '0) begin
			na = AW'(1);
		end else if (32'(ac_q) > MAX_ATOMS) begin
			na = AW'(MAX_ATOMS);
		end else begin
			na = AW'(ac_q);
		end
		res = (pc_q == '0) ? PC_W'(1) : pc_q;
		tr  = (tr_q > TR_ONE) ? TR_ONE : tr_q;
	end

	assign traj.ready = (state_q == ST_LOAD);
	assign acc_in     = traj.valid && traj.ready;
	assign pos_we     = acc_in && (fr_q < nf);
	assign typ_we     = pos_we && (fr_q == '0);
	assign ld_addr    = base_q + ADW'(at_q);
	assign load_last  = (32'(at_q) == 32'(na) - 1);
	assign atom_last  = (32'(j_q) == 32'(na) - 1);
	assign emit_ok    = !ov_q || result.ready;
	assign type_hit   = (typ_rd == tt_q);

	msd_ram #(.W(PW), .D(DEPTH)) u_pos_ram (
		.clk    (clk),
		.we     (pos_we),
		.waddr  (ld_addr),
		.wdata  ({traj.pos_z, traj.pos_y, traj.pos_x}),
		.raddr0 (a0_q),
		.raddr1 (a1_q),
		.rdata0 (rd0),
		.rdata1 (rd1)
	);

	msd_ram #(.W(TYPE_W), .D(MAX_ATOMS)) u_type_ram (
		.clk    (clk),
		.we     (typ_we),
		.waddr  (at_q),
		.wdata  (traj.atom_type),
		.raddr0 (j_q),
		.raddr1 (j_q),
		.rdata0 (typ_rd),
		.rdata1 ()
	);

	// lag: floor((i*tr*nf + res*2^15) / 2^16 / res)
	assign div_num = (state_q == ST_LAG_DIV) ? DIV_N'(num_q[NUM_W-1:16]) : acc_q;
	assign div_dvs = (state_q == ST_LAG_DIV) ? DIV_D'(res) : dvs_q;

	msd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (go_q),
		.dividend (div_num),
		.divisor  (div_dvs),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			fr_q    <= '0;
			at_q    <= '0;
			base_q  <= '0;
			j_q     <= '0;
			tcnt_q  <= '0;
			i_q     <= '0;
			k_q     <= '0;
			go_q    <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			go_q <= 1'b0;
			case (state_q)
				ST_LOAD: begin
					if (acc_in) begin
						if (fr_q < nf) begin
							if (load_last) begin
								at_q   <= '0;
								fr_q   <= fr_q + FW'(1);
								base_q <= base_q + ADW'(MAX_ATOMS);
							end else begin
								at_q <= at_q + AIW'(1);
							end
						end
						if (traj.last_record) begin
							j_q     <= '0;
							tcnt_q  <= '0;
							state_q <= ST_CNT_RD;
						end
					end
				end
				ST_CNT_RD: state_q <= ST_CNT_CHK;
				ST_CNT_CHK: begin
					if (type_hit) begin
						tcnt_q <= tcnt_q + AW'(1);
					end
					if (atom_last) begin
						i_q     <= '0;
						state_q <= ST_LAG_M1;
					end else begin
						j_q     <= j_q + AIW'(1);
						state_q <= ST_CNT_RD;
					end
				end
				ST_LAG_M1: state_q <= ST_LAG_M2;
				ST_LAG_M2: begin
					go_q    <= 1'b1;
					state_q <= ST_LAG_DIV;
				end
				ST_LAG_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_LAG_CHK;
					end
				end
				ST_LAG_CHK: begin
					j_q <= '0;
					if (lag_q < nf && tcnt_q != '0) begin
						state_q <= ST_ATOM_RD;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_ATOM_RD: state_q <= ST_ATOM_CHK;
				ST_ATOM_CHK: begin
					k_q <= '0;
					if (type_hit) begin
						state_q <= ST_PAIR;
					end else if (atom_last) begin
						state_q <= ST_SUM_M;
					end else begin
						j_q     <= j_q + AIW'(1);
						state_q <= ST_ATOM_RD;
					end
				end
				ST_PAIR: begin
					k_q <= k_q + FW'(1);
					if (k_q == win_q - FW'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2 && !v_s3) begin
						if (atom_last) begin
							state_q <= ST_SUM_M;
						end else begin
							j_q     <= j_q + AIW'(1);
							state_q <= ST_ATOM_RD;
						end
					end
				end
				ST_SUM_M: begin
					go_q    <= 1'b1;
					state_q <= ST_SUM_DIV;
				end
				ST_SUM_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_ok) begin
						if (i_q == res) begin
							fr_q    <= '0;
							at_q    <= '0;
							base_q  <= '0;
							state_q <= ST_LOAD;
						end else begin
							i_q     <= i_q + PC_W'(1);
							state_q <= ST_LAG_M1;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
			if (state_q == ST_EMIT && emit_ok) begin
				ov_q <= 1'b1;
			end else if (result.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_LAG_M1: p1_q <= P1_W'(i_q) * P1_W'(tr);
			ST_LAG_M2: num_q <= NUM_W'(p1_q) * NUM_W'(nf) + (NUM_W'(res) << 15);
			ST_LAG_DIV: begin
				if (div_quo > DIV_N'(nf)) begin
					lag_q <= nf;
				end else begin
					lag_q <= FW'(div_quo);
				end
			end
			ST_LAG_CHK: begin
				win_q <= nf - lag_q;
				acc_q <= '0;
				val_q <= '0;
			end
			ST_ATOM_CHK: begin
				a0_q <= ADW'(j_q);
				a1_q <= ADW'(32'(lag_q) * MAX_ATOMS + 32'(j_q));
			end
			ST_PAIR: begin
				a0_q <= a0_q + ADW'(MAX_ATOMS);
				a1_q <= a1_q + ADW'(MAX_ATOMS);
			end
			ST_SUM_M: dvs_q <= DIV_D'(32'(tcnt_q) * 32'(win_q));
			ST_SUM_DIV: val_q <= div_quo[MSD_W-1:0];
			default: ;
		endcase
		if (v_s3) begin
			acc_q <= acc_q + ACC_W'($unsigned(sx_s3)) + ACC_W'($unsigned(sy_s3))
				+ ACC_W'($unsigned(sz_s3));
		end
		if (state_q == ST_EMIT && emit_ok) begin
			olag_q  <= lag_q;
			oval_q  <= val_q;
			olast_q <= (i_q == res);
		end
	end

	// displacement pipeline: RAM read, difference, square, accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_PAIR);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s2 <= DW'($signed(rd1[COORD_BITS-1:0])) - DW'($signed(rd0[COORD_BITS-1:0]));
		dy_s2 <= DW'($signed(rd1[2*COORD_BITS-1:COORD_BITS]))
			- DW'($signed(rd0[2*COORD_BITS-1:COORD_BITS]));
		dz_s2 <= DW'($signed(rd1[PW-1:2*COORD_BITS])) - DW'($signed(rd0[PW-1:2*COORD_BITS]));
		sx_s3 <= dx_s2 * dx_s2;
		sy_s3 <= dy_s2 * dy_s2;
		sz_s3 <= dz_s2 * dz_s2;
	end

	logic [31:0] olag_w;
	assign olag_w = 32'(olag_q);

	assign result.valid      = ov_q;
	assign result.lag_frames = olag_w[LAG_OUT_W-1:0];
	assign result.msd_value  = oval_q;
	assign result.last_point = olast_q;
endmodule
